// ===== design/drwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drwm_pkg: shared types and constants of the DNA repeat word masker
// Word types of both channels, register map, symbol decoding and sizes.
// ----------------------------------------------------------------------------
package drwm_pkg;

  // Sizes of the design
  localparam int MAX_KEY_BASES = 8;
  localparam int POSITION_BITS = 32;
  localparam int WIN_BITS      = 4 * MAX_KEY_BASES;
  localparam int LEN_BITS      = $clog2(MAX_KEY_BASES + 1);
  localparam int CNT_BITS      = 4;
  localparam int SCORE_BITS    = 32;
  localparam int SPAN_BITS     = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  // Largest run score; the score saturates here
  localparam logic [SCORE_BITS:0] SCORE_MAX = (SCORE_BITS + 1)'(32'h7FFF_FFFF);

  // Pad symbol '*'
  localparam logic [7:0] PAD_SYMBOL = 8'h2A;

  // Register indexes (byte address 4*index)
  typedef enum logic [2:0] {
    REG_KEY_PATTERN = 3'd0,
    REG_KEY_LENGTH  = 3'd1,
    REG_KEY_PERIOD  = 3'd2,
    REG_MIN_SIZE    = 3'd3,
    REG_MAX_DROP    = 3'd4,
    REG_FILL_SYMBOL = 3'd5
  } cfg_reg_e;

  // Input word
  typedef struct packed {
    logic [7:0] base_symbol;
    logic       last_item;
  } base_item_t;

  // Output word
  typedef struct packed {
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [7:0]  region_fill;
  } region_item_t;

  // Map a sequence character to its IUPAC ambiguity mask; unknown gives zero
  function automatic logic [3:0] iupac_mask(input logic [7:0] sym);
    logic [7:0] c;
    logic [3:0] m;
    c = sym;
    if (sym >= "a" && sym <= "z") begin
      c = sym - 8'h20;
    end
    case (c)
      "A":      m = 4'd1;
      "C":      m = 4'd2;
      "G":      m = 4'd4;
      "T", "U": m = 4'd8;
      "M":      m = 4'd3;
      "R":      m = 4'd5;
      "S":      m = 4'd6;
      "V":      m = 4'd7;
      "W":      m = 4'd9;
      "Y":      m = 4'd10;
      "H":      m = 4'd11;
      "K":      m = 4'd12;
      "D":      m = 4'd13;
      "B":      m = 4'd14;
      "N":      m = 4'd15;
      default:  m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/dna_repeat_word_masker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_repeat_word_masker_core: repeat word region finder
// Scores a stream of DNA symbols against a masked repeat word and reports
// regions worth filling as start, end and fill byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | base_item_t  (symbol, last)
//  out     | output    | out_valid_o/out_ready_i | region_item_t (start,end,fill)
//  cfg     | input     | APB psel/penable        | 32-bit registers at 4*index
//
//  One symbol per cycle while the output is not stalled: an accepted word
//  is registered in the input register, then one pass of score logic
//  updates the state and loads a region, if any, into the output register.
//  Reset clears valid flags and scan state; registers take their defaults at once.
//  A stalled output holds its region; the input register keeps taking words
//  as long as the pass can retire into the output register.
// ----------------------------------------------------------------------------
module dna_repeat_word_masker_core
  import drwm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // sequence symbols
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  base_item_t               in_data_i,
  // regions
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output region_item_t             out_data_o,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // Configuration registers
  logic [31:0] key_pattern_q;
  logic [3:0]  key_length_q;
  logic [3:0]  key_period_q;
  logic [15:0] min_size_q;
  logic [15:0] max_drop_q;
  logic [7:0]  fill_symbol_q;

  // Input register
  logic       in_valid_q;
  base_item_t in_data_q;

  // Scan state
  logic [WIN_BITS-1:0]      win_q, win_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [CNT_BITS-1:0]      fill_q, fill_d;
  logic [CNT_BITS-1:0]      skip_q, skip_d;
  logic [SCORE_BITS-1:0]    score_q, score_d;
  logic [SCORE_BITS-1:0]    best_q, best_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] end_q, end_d;
  logic [31:0]              pad_q, pad_d;

  // Output register
  logic         out_valid_q, out_valid_d;
  region_item_t out_data_q, out_data_d;

  // Step values before close and flush clearing
  logic [WIN_BITS-1:0]      win_n;
  logic [CNT_BITS-1:0]      fill_n, skip_n;
  logic [SCORE_BITS-1:0]    score_n, best_n;
  logic [POSITION_BITS-1:0] start_n, end_n;
  logic [31:0]              pad_n;
  logic                     close;

  logic                     proc_go;
  logic                     cfg_wr;
  logic [2:0]               cfg_idx;
  logic [LEN_BITS-1:0]      len;
  logic [CNT_BITS-1:0]      len_m1;
  logic [CNT_BITS-1:0]      per, per_m1;
  logic [WIN_BITS-1:0]      wmask, key, win_shift;
  logic                     is_pad, hit, no_region;
  logic [SCORE_BITS-1:0]    score_base, best_base, score_sat;
  logic [SCORE_BITS:0]      score_sum, drop_lhs;
  logic [POSITION_BITS-1:0] open_start, span_d;
  logic [SPAN_BITS-1:0]     span;
  logic                     rep_try, rep_ok;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pattern_q <= '0;
      key_length_q  <= 4'd1;
      key_period_q  <= 4'd1;
      min_size_q    <= '0;
      max_drop_q    <= 16'd1;
      fill_symbol_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_idx))
        REG_KEY_PATTERN: key_pattern_q <= pwdata;
        REG_KEY_LENGTH:  key_length_q  <= pwdata[3:0];
        REG_KEY_PERIOD:  key_period_q  <= pwdata[3:0];
        REG_MIN_SIZE:    min_size_q    <= pwdata[15:0];
        REG_MAX_DROP:    max_drop_q    <= pwdata[15:0];
        REG_FILL_SYMBOL: fill_symbol_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_reg_e'(cfg_idx))
      REG_KEY_PATTERN: prdata = key_pattern_q;
      REG_KEY_LENGTH:  prdata = CFG_DATA_BITS'(key_length_q);
      REG_KEY_PERIOD:  prdata = CFG_DATA_BITS'(key_period_q);
      REG_MIN_SIZE:    prdata = CFG_DATA_BITS'(min_size_q);
      REG_MAX_DROP:    prdata = CFG_DATA_BITS'(max_drop_q);
      REG_FILL_SYMBOL: prdata = CFG_DATA_BITS'(fill_symbol_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign proc_go    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_go;

  // Capture incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Word geometry
  // --------------------------------------------------------------------------
  // Clamp length to 1..MAX_KEY_BASES, period zero acts as one
  always_comb begin
    if (key_length_q == 4'd0) begin
      len = LEN_BITS'(1);
    end else if (32'(key_length_q) > 32'(MAX_KEY_BASES)) begin
      len = LEN_BITS'(MAX_KEY_BASES);
    end else begin
      len = LEN_BITS'(key_length_q);
    end
  end

  assign len_m1 = CNT_BITS'(len - LEN_BITS'(1));
  assign per    = (key_period_q == 4'd0) ? 4'd1 : key_period_q;
  assign per_m1 = per - 4'd1;

  // Window mask: one nibble per base in use
  always_comb begin
    for (int i = 0; i < MAX_KEY_BASES; i++) begin
      wmask[4*i +: 4] = (32'(i) < 32'(len)) ? 4'hF : 4'h0;
    end
  end

  assign key       = WIN_BITS'(key_pattern_q);
  assign is_pad    = (in_data_q.base_symbol == PAD_SYMBOL);
  assign win_shift = ((win_q << 4) | WIN_BITS'(iupac_mask(in_data_q.base_symbol))) & wmask;
  assign hit       = ((win_shift & key) != '0) && ((win_shift & ~key & wmask) == '0);
  assign no_region = score_q[SCORE_BITS-1];

  // --------------------------------------------------------------------------
  // Score arithmetic
  // --------------------------------------------------------------------------
  // Match: open at zero if no region, add period, saturate
  assign score_base = no_region ? '0 : score_q;
  assign best_base  = no_region ? '0 : best_q;
  assign score_sum  = {1'b0, score_base} + (SCORE_BITS + 1)'(per);
  assign score_sat  = (score_sum > SCORE_MAX) ? SCORE_BITS'(SCORE_MAX) : score_sum[SCORE_BITS-1:0];
  assign open_start = pos_q - POSITION_BITS'(len_m1);

  // Mismatch: score-1 <= best-max_drop, rearranged to stay unsigned
  assign drop_lhs = {1'b0, score_q} - (SCORE_BITS + 1)'(1) + (SCORE_BITS + 1)'(max_drop_q);

  // --------------------------------------------------------------------------
  // One scan step
  // --------------------------------------------------------------------------
  always_comb begin
    win_n   = win_q;
    fill_n  = fill_q;
    skip_n  = skip_q;
    score_n = score_q;
    best_n  = best_q;
    start_n = start_q;
    end_n   = end_q;
    pad_n   = pad_q;
    close   = 1'b0;
    if (is_pad) begin
      pad_n = pad_q + 32'd1;
    end else begin
      win_n = win_shift;
      if (fill_q < len_m1) begin
        fill_n = fill_q + CNT_BITS'(1);
      end else if (skip_q != '0) begin
        skip_n = skip_q - CNT_BITS'(1);
      end else if (hit) begin
        if (no_region) begin
          pad_n   = '0;
          start_n = open_start;
        end
        score_n = score_sat;
        best_n  = best_base;
        if (score_sat >= best_base) begin
          best_n = score_sat;
          end_n  = pos_q;
        end
        skip_n = per_m1;
      end else if (!no_region) begin
        score_n = score_q - SCORE_BITS'(1);
        close   = (score_q == '0) || (drop_lhs <= {1'b0, best_q});
      end else begin
        pad_n   = '0;
        score_n = '1;
      end
    end
  end

  // Region length minus pads against the minimum, signed
  assign span_d  = end_n - start_n;
  assign span    = SPAN_BITS'(span_d) + SPAN_BITS'(1) - SPAN_BITS'(pad_n);
  assign rep_ok  = $signed(span) >= $signed(SPAN_BITS'(min_size_q));
  assign rep_try = close || (in_data_q.last_item && !score_n[SCORE_BITS-1]);

  // Apply close and end-of-sequence clearing
  always_comb begin
    win_d   = win_n;
    fill_d  = fill_n;
    skip_d  = skip_n;
    score_d = score_n;
    best_d  = best_n;
    start_d = start_n;
    end_d   = end_n;
    pad_d   = pad_n;
    pos_d   = pos_q + POSITION_BITS'(1);
    if (close) begin
      score_d = '1;
      pad_d   = '0;
      best_d  = '0;
    end
    if (in_data_q.last_item) begin
      win_d   = '0;
      fill_d  = '0;
      skip_d  = '0;
      score_d = '1;
      best_d  = '0;
      start_d = '0;
      end_d   = '0;
      pad_d   = '0;
      pos_d   = '0;
    end
  end

  // Advance scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      fill_q  <= '0;
      skip_q  <= '0;
      score_q <= '1;
      best_q  <= '0;
      start_q <= '0;
      end_q   <= '0;
      pad_q   <= '0;
    end else if (proc_go) begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      skip_q  <= skip_d;
      score_q <= score_d;
      best_q  <= best_d;
      start_q <= start_d;
      end_q   <= end_d;
      pad_q   <= pad_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (proc_go && rep_try && rep_ok) begin
      out_valid_d             = 1'b1;
      out_data_d.region_start = 32'(start_n);
      out_data_d.region_end   = 32'(end_n);
      out_data_d.region_fill  = fill_symbol_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/drwm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drwm_checker: port-level checks of the repeat word masker
// Watches the top level ports and flags stalls, lost words and port slips.
// ----------------------------------------------------------------------------
module drwm_checker
  import drwm_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_o,
  input logic         out_valid_o,
  input logic         out_ready_i,
  input region_item_t out_data_o,
  input logic         psel,
  input logic         penable,
  input logic         pready
);

  // Hold a stalled region word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled region word changed or dropped");

  // Never refuse input while the output side is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with empty output register");

  // Refuse input only with a stalled output behind it
  a_ready_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused while output drains");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("configuration access stalled");

  // Input valid seen while idle must be taken on the spot
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !out_valid_o |-> in_ready_o)
    else $error("input word not taken while idle");

endmodule

bind dna_repeat_word_masker_core drwm_checker u_drwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pready      (pready)
);

// ===== bench/dna_repeat_word_masker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_repeat_word_masker_core_tb: self-checking bench of the repeat word masker
// Drives symbol words with random gaps, stalls the region channel at random,
// programs the registers over the APB port between phases, predicts every
// region in step with accepted symbols and checks each region as it leaves.
// ----------------------------------------------------------------------------
module dna_repeat_word_masker_core_tb;
  import drwm_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int STALL_MAX    = 6;
  localparam int QUIET_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 8;

  // IUPAC letters ordered by mask 1..15, first letter in the top byte
  localparam logic [8*15-1:0] IUPAC_LETTERS   = "ACMGRSVTWYHKDBN";
  // letters that carry no IUPAC meaning
  localparam logic [8*10-1:0] FOREIGN_LETTERS = "EFIJLOPQXZ";

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  base_item_t               in_data_i   = '0;
  logic                     out_ready_i = 1'b0;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr       = '0;
  logic [CFG_DATA_BITS-1:0] pwdata      = '0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  region_item_t             out_data_o;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  dna_repeat_word_masker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // Register shadow
  logic [31:0] key_cfg  = 32'd0;
  int          len_cfg  = 1;
  int          per_cfg  = 1;
  int          min_cfg  = 0;
  int          drop_cfg = 1;
  logic [7:0]  fill_cfg = 8'd0;

  // Scanner state shadow
  logic [31:0] win_word   = 32'd0;
  logic [31:0] pos_cnt    = 32'd0;
  int          fill_cnt   = 0;
  int          skip_cnt   = 0;
  longint      run_score  = -1;
  longint      best_score = 0;
  logic [31:0] run_start  = 32'd0;
  logic [31:0] run_end    = 32'd0;
  logic [31:0] pad_cnt    = 32'd0;

  logic [3:0]   base_code [256];
  region_item_t region_q [$];
  int           err_count  = 0;
  int           items_sent = 0;
  bit           idle_on    = 1'b1;
  int           ready_hold = 0;
  int           quiet_cycles = 0;

  // Current repeat unit for the random phases
  logic [3:0] unit_mask [8];
  int         unit_len = 1;

  // Build the symbol to mask table
  initial begin : build_code_table
    logic [7:0] c;
    for (int i = 0; i < 256; i++) base_code[i] = 4'd0;
    for (int m = 1; m < 16; m++) begin
      c = IUPAC_LETTERS[8*(15-m) +: 8];
      base_code[c] = 4'(m);
      base_code[c + 8'h20] = 4'(m);
    end
    base_code["U"] = 4'd8;
    base_code["u"] = 4'd8;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Close check: length minus pads against min size, signed
  function automatic bit region_fits(output region_item_t r);
    logic [31:0] delta;
    longint      span;
    delta = run_end - run_start;
    span = $signed({32'd0, delta}) + 1 - $signed({32'd0, pad_cnt});
    r.region_start = run_start;
    r.region_end   = run_end;
    r.region_fill  = fill_cfg;
    return span >= longint'(min_cfg);
  endfunction

  // Advance the scanner shadow by one symbol and queue the region it closes
  function automatic void score_base(input base_item_t word);
    logic [31:0]  p;
    logic [31:0]  wmask;
    int           len;
    int           per;
    bit           hit;
    region_item_t r;
    p   = pos_cnt;
    hit = 1'b0;
    if (word.base_symbol == PAD_SYMBOL) begin
      pad_cnt++;
    end else begin
      len = (len_cfg < 1) ? 1 : (len_cfg > MAX_KEY_BASES) ? MAX_KEY_BASES : len_cfg;
      per = (per_cfg == 0) ? 1 : per_cfg;
      wmask = 32'((64'd1 << (4 * len)) - 64'd1);
      win_word = ((win_word << 4) | 32'(base_code[word.base_symbol])) & wmask;
      if (fill_cnt < len - 1) begin
        fill_cnt++;
      end else if (skip_cnt > 0) begin
        skip_cnt--;
      end else if ((win_word & key_cfg) != 0 && (win_word & ~key_cfg & wmask) == 0) begin
        // open on the first match, then score and skip the rest of the period
        if (run_score < 0) begin
          pad_cnt    = 32'd0;
          best_score = 0;
          run_score  = 0;
          run_start  = p - 32'(len - 1);
        end
        run_score += per;
        if (run_score > 64'sd2147483647) run_score = 64'sd2147483647;
        if (run_score >= best_score) begin
          best_score = run_score;
          run_end    = p;
        end
        skip_cnt = per - 1;
      end else if (run_score >= 0) begin
        run_score--;
        if (run_score < 0 || run_score <= best_score - longint'(drop_cfg)) begin
          hit        = region_fits(r);
          run_score  = -1;
          pad_cnt    = 32'd0;
          best_score = 0;
        end
      end else begin
        pad_cnt   = 32'd0;
        run_score = -1;
      end
    end
    pos_cnt = p + 32'd1;
    // flush an open region and drop all state on the last symbol
    if (word.last_item) begin
      if (run_score >= 0 && !hit) hit = region_fits(r);
      win_word   = 32'd0;
      pos_cnt    = 32'd0;
      fill_cnt   = 0;
      skip_cnt   = 0;
      run_score  = -1;
      best_score = 0;
      run_start  = 32'd0;
      run_end    = 32'd0;
      pad_cnt    = 32'd0;
    end
    if (hit) region_q.push_back(r);
  endfunction

  // Predict on every accepted symbol word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) score_base(in_data_i);
  end

  // Check every accepted region word against the oldest prediction
  always @(posedge clk_i) begin : check_region
    region_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (region_q.size() == 0) begin
        report_mismatch($sformatf("unexpected region %h..%h fill %h",
          out_data_o.region_start, out_data_o.region_end, out_data_o.region_fill));
      end else begin
        want = region_q.pop_front();
        if (out_data_o.region_start !== want.region_start)
          report_mismatch($sformatf("region_start got %h want %h",
            out_data_o.region_start, want.region_start));
        if (out_data_o.region_end !== want.region_end)
          report_mismatch($sformatf("region_end got %h want %h",
            out_data_o.region_end, want.region_end));
        if (out_data_o.region_fill !== want.region_fill)
          report_mismatch($sformatf("region_fill got %h want %h",
            out_data_o.region_fill, want.region_fill));
      end
    end
  end

  // Drop ready for a random number of cycles after each region word
  always @(posedge clk_i) begin : drive_out_ready
    int w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        w = idle_on ? $urandom_range(0, STALL_MAX) : 0;
        ready_hold  <= w;
        out_ready_i <= (w == 0);
      end else if (ready_hold != 0) begin
        ready_hold  <= ready_hold - 1;
        out_ready_i <= (ready_hold == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("dna_repeat_word_masker_core_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Random letter for a mask; zero gives a letter with no IUPAC meaning
  function automatic logic [7:0] letter_for(input logic [3:0] m);
    logic [7:0] c;
    if (m == 4'd0) c = FOREIGN_LETTERS[8*$urandom_range(0, 9) +: 8];
    else if (m == 4'd8 && $urandom_range(0, 3) == 0) c = "U";
    else c = IUPAC_LETTERS[8*(15-int'(m)) +: 8];
    if ($urandom_range(0, 3) == 0) c = c + 8'h20;
    return c;
  endfunction

  // Send one symbol word after a random gap, hold it until accepted
  task automatic send_base(input logic [7:0] sym, input logic last);
    int         gap;
    base_item_t w;
    gap = idle_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    w.base_symbol = sym;
    w.last_item   = last;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Stop sending, wait for all regions, then let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (region_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup then access; the caller releases the bus
  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_KEY_PATTERN: key_cfg  = val;
      REG_KEY_LENGTH:  len_cfg  = int'(val[3:0]);
      REG_KEY_PERIOD:  per_cfg  = int'(val[3:0]);
      REG_MIN_SIZE:    min_cfg  = int'(val[15:0]);
      REG_MAX_DROP:    drop_cfg = int'(val[15:0]);
      REG_FILL_SYMBOL: fill_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] key, input int len, input int per,
                              input int min_size, input int max_drop,
                              input logic [7:0] fill);
    wait_idle();
    cfg_write(REG_KEY_PATTERN, key);
    cfg_write(REG_KEY_LENGTH, 32'(len));
    cfg_write(REG_KEY_PERIOD, 32'(per));
    cfg_write(REG_MIN_SIZE, 32'(min_size));
    cfg_write(REG_MAX_DROP, 32'(max_drop));
    cfg_write(REG_FILL_SYMBOL, 32'(fill));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Default registers: empty key, nothing ever matches
  task automatic test_reset_defaults();
    send_base("A", 1'b0);
    send_base(PAD_SYMBOL, 1'b0);
    send_base("n", 1'b1);
  endtask

  // Two-base word, close on a mismatch that is also the last symbol
  task automatic test_match_and_close();
    program_regs(32'h0000_0021, 2, 2, 0, 1, 8'hFF);
    send_base("C", 1'b0);
    send_base("A", 1'b0);
    send_base("c", 1'b0);
    send_base("a", 1'b0);
    send_base(PAD_SYMBOL, 1'b0);
    send_base("G", 1'b0);
    send_base("x", 1'b1);
  endtask

  // Pads after the best score push length minus pads below zero
  task automatic test_negative_span();
    program_regs(32'h0000_0021, 2, 1, 0, 1, 8'h5A);
    send_base("C", 1'b0);
    send_base("A", 1'b0);
    repeat (4) send_base(PAD_SYMBOL, 1'b0);
    send_base("g", 1'b1);
  endtask

  // Length and period of zero act as one; flush at the last symbol
  task automatic test_key_range();
    program_regs(32'h0000_0008, 0, 0, 2, 1, 8'h00);
    send_base("t", 1'b0);
    send_base("T", 1'b1);
  endtask

  // Length above the maximum acts as the maximum; last lands in the skip
  task automatic test_long_key_skip();
    program_regs(32'hFFFF_FFFF, 12, 3, 0, 65535, 8'h00);
    repeat (8) send_base("N", 1'b0);
    send_base("a", 1'b1);
  endtask

  // One sequence: background and repeat runs, or plain noise
  task automatic send_sequence(input bit with_last);
    logic [7:0] seq [$];
    logic [3:0] m;
    int         segs;
    int         n;
    int         j0;
    int         roll;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(5, 60);
      for (int k = 0; k < n; k++) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) seq.push_back(PAD_SYMBOL);
        else if (roll < 5) seq.push_back(8'($urandom_range(0, 255)));
        else seq.push_back(letter_for(4'($urandom_range(0, 15))));
      end
    end else begin
      segs = $urandom_range(1, 4);
      for (int s = 0; s < segs; s++) begin
        n = $urandom_range(0, 10);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0) seq.push_back(8'($urandom_range(0, 255)));
          else seq.push_back(letter_for(4'(1 << $urandom_range(0, 3))));
        end
        n  = $urandom_range(1, 40);
        j0 = $urandom_range(0, unit_len - 1);
        for (int k = 0; k < n; k++) begin
          m    = unit_mask[(j0 + k) % unit_len];
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            seq.push_back(8'($urandom_range(0, 255)));
          end else if (roll < 8) begin
            seq.push_back(PAD_SYMBOL);
            seq.push_back(letter_for(m));
          end else if (roll < 20) begin
            // any nonzero part of the key mask still matches
            m = m & 4'($urandom_range(1, 15));
            if (m == 4'd0) m = unit_mask[(j0 + k) % unit_len];
            seq.push_back(letter_for(m));
          end else begin
            seq.push_back(letter_for(m));
          end
        end
      end
    end
    for (int i = 0; i < seq.size(); i++)
      send_base(seq[i], with_last && (i == seq.size() - 1));
  endtask

  // Phases of random words under a fresh register setting each
  task automatic test_random_phases();
    logic [31:0] key;
    logic [7:0]  fill_reg;
    int          l;
    int          len_reg;
    int          per_reg;
    int          min_reg;
    int          drop_reg;
    int          seqs;
    int          target;
    int          phase;
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      unit_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 9) < 7) unit_mask[i] = 4'(1 << $urandom_range(0, 3));
        else unit_mask[i] = 4'($urandom_range(1, 15));
      end
      l = ($urandom_range(0, 4) != 0) ? $urandom_range(unit_len, 8) : $urandom_range(1, 8);
      key = 32'd0;
      for (int i = 0; i < l; i++) key = (key << 4) | 32'(unit_mask[i % unit_len]);
      // junk above the window must not matter
      if (l < 8 && $urandom_range(0, 2) == 0) key = key | ($urandom() << (4 * l));
      len_reg = l;
      if (l == 1 && $urandom_range(0, 3) == 0) len_reg = 0;
      if (l == 8 && $urandom_range(0, 3) == 0) len_reg = $urandom_range(9, 15);
      per_reg = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : unit_len;
      case ($urandom_range(0, 9))
        0:       min_reg = 0;
        1:       min_reg = 65535;
        2:       min_reg = $urandom_range(0, 65535);
        default: min_reg = $urandom_range(0, 30);
      endcase
      case ($urandom_range(0, 9))
        0:       drop_reg = 0;
        1:       drop_reg = 65535;
        2:       drop_reg = $urandom_range(0, 65535);
        default: drop_reg = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 3))
        0:       fill_reg = 8'h00;
        1:       fill_reg = 8'hFF;
        default: fill_reg = 8'($urandom_range(0, 255));
      endcase
      program_regs(key, len_reg, per_reg, min_reg, drop_reg, fill_reg);
      seqs = $urandom_range(2, 5);
      for (int s = 0; s < seqs; s++) begin
        // hold the sender until every region is out, always in the first phase
        if (s == seqs / 2 && (phase == 0 || $urandom_range(0, 1) == 0)) wait_idle();
        send_sequence(!(s == seqs - 1 && $urandom_range(0, 3) == 0));
      end
      phase++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_match_and_close();
    test_negative_span();
    test_key_range();
    test_long_key_skip();
    test_random_phases();
    wait_idle();
    if (err_count == 0) begin
      $display("dna_repeat_word_masker_core_tb: clean");
    end else begin
      $display("dna_repeat_word_masker_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/drwm_pkg.sv
design/dna_repeat_word_masker_core.sv
design/drwm_checker.sv
bench/dna_repeat_word_masker_core_tb.sv
